// ----- rtl/sdx_pkg.sv -----
`default_nettype none
package sdx_pkg;

    localparam int CODE_LENGTH_DEF = 4;

    typedef logic [2:0] t_code;

    localparam t_code SKIP_CODE  = 3'd0;  // H, W
    localparam t_code VOWEL_CODE = 3'd7;  // A E I O U Y

    localparam logic [7:0] ASCII_UPPER_A = 8'h41;
    localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
    localparam logic [7:0] ASCII_LOWER_A = 8'h61;
    localparam logic [7:0] ASCII_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_OFFSET   = 8'h20;
    localparam logic [6:0] NO_LEAD_CHAR  = 7'h30;  // '0'

    // Classifier result for one input byte
    typedef struct packed {
        logic       is_letter;
        logic [6:0] letter;     // upper case ASCII
        t_code      code;
    } t_class;

    function automatic t_code letter_code(input logic [4:0] idx);
        t_code c;
        case (idx)
            5'd0, 5'd4, 5'd8, 5'd14, 5'd20, 5'd24:           c = VOWEL_CODE;
            5'd1, 5'd5, 5'd15, 5'd21:                         c = 3'd1;
            5'd2, 5'd6, 5'd9, 5'd10, 5'd16, 5'd18, 5'd23, 5'd25: c = 3'd2;
            5'd3, 5'd19:                                      c = 3'd3;
            5'd11:                                            c = 3'd4;
            5'd12, 5'd13:                                     c = 3'd5;
            5'd17:                                            c = 3'd6;
            default:                                          c = SKIP_CODE;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/sdx_classify.sv -----
`default_nettype none
module sdx_classify (
    input  wire logic [7:0]      i_ch,
    output sdx_pkg::t_class      o_class
);
    import sdx_pkg::*;

    logic [7:0] up;
    logic [7:0] idx;

    always_comb begin
        up = i_ch;
        if (i_ch inside {[ASCII_LOWER_A:ASCII_LOWER_Z]}) begin
            up = i_ch - CASE_OFFSET;
        end
        idx = up - ASCII_UPPER_A;
        o_class.is_letter = (up inside {[ASCII_UPPER_A:ASCII_UPPER_Z]});
        o_class.letter    = up[6:0];
        o_class.code      = letter_code(idx[4:0]);
    end

endmodule
`default_nettype wire

// ----- rtl/soundex_encoder.sv -----
`default_nettype none
// Channel  | dir | tdata fields (low bit first)                          | tlast
// s side   | in  | ch[7:0]                                               | last
// m side   | out | lead_char[6:0] digit_one[9:7] two[12:10] three[15:13] | -
//
// One byte per cycle sustained unless a word end waits on a stalled result; the
// result word is registered: the closing byte enters the input register, then the
// code update goes into the result register.
// Reset clears the word state and both valid flags.
// A stalled result only blocks the input stage when the waiting byte ends a
// word; ordinary bytes keep flowing into the word state.
module soundex_encoder #(
    parameter int CODE_LENGTH = sdx_pkg::CODE_LENGTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // ch
    input  wire logic        i_s_tlast,   // last
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [15:0]      o_m_tdata    // lead_char, digit_one, digit_two, digit_three
);
    import sdx_pkg::*;

    localparam int NDIG = CODE_LENGTH - 1;
    localparam int CW   = $clog2(NDIG + 1);

    logic         r_in_vld;
    logic [7:0]   r_in_ch;
    logic         r_in_last;
    logic         proc;
    t_class       cls;

    logic         r_have_lead, n_have_lead;
    logic         r_merging,   n_merging;
    logic [6:0]   r_lead,      n_lead;
    t_code        r_lead_code, n_lead_code;
    t_code        r_prev,      n_prev;
    logic [CW-1:0] r_cnt,      n_cnt;
    t_code        r_dig [NDIG];
    t_code        n_dig [NDIG];

    logic         r_out_vld;
    logic [15:0]  r_out_data;
    t_code        out_dig [3];

    assign proc       = r_in_vld && (!r_in_last || !r_out_vld || i_m_tready);
    assign o_s_tready = !r_in_vld || proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_tready) begin
            r_in_vld <= i_s_tvalid;
        end
        if (o_s_tready && i_s_tvalid) begin
            r_in_ch   <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    sdx_classify u_classify (
        .i_ch    (r_in_ch),
        .o_class (cls)
    );

    always_comb begin
        n_have_lead = r_have_lead;
        n_merging   = r_merging;
        n_lead      = r_lead;
        n_lead_code = r_lead_code;
        n_prev      = r_prev;
        n_cnt       = r_cnt;
        n_dig       = r_dig;
        if (cls.is_letter) begin
            if (!r_have_lead) begin
                n_have_lead = 1'b1;
                n_lead      = cls.letter;
                n_lead_code = cls.code;
                n_merging   = (cls.code != SKIP_CODE) && (cls.code != VOWEL_CODE);
                n_prev      = SKIP_CODE;
            end else if (cls.code == SKIP_CODE) begin
                n_prev = r_prev;
            end else if (r_merging && cls.code == r_lead_code) begin
                n_merging = 1'b1;
            end else begin
                n_merging = 1'b0;
                if (cls.code != r_prev) begin
                    n_prev = cls.code;
                    if (cls.code != VOWEL_CODE && r_cnt < CW'(NDIG)) begin
                        for (int k = 0; k < NDIG; k++) begin
                            if (r_cnt == CW'(k)) begin
                                n_dig[k] = cls.code;
                            end
                        end
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
        end
    end

    // digits past the stored slots read as padding
    for (genvar g = 0; g < 3; g++) begin : g_out
        if (g < NDIG) begin : g_have
            assign out_dig[g] = n_dig[g];
        end else begin : g_pad
            assign out_dig[g] = SKIP_CODE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_lead <= 1'b0;
            r_merging   <= 1'b0;
            r_lead      <= '0;
            r_lead_code <= SKIP_CODE;
            r_prev      <= SKIP_CODE;
            r_cnt       <= '0;
            for (int k = 0; k < NDIG; k++) begin
                r_dig[k] <= SKIP_CODE;
            end
        end else if (proc) begin
            if (r_in_last) begin
                r_have_lead <= 1'b0;
                r_merging   <= 1'b0;
                r_lead      <= '0;
                r_lead_code <= SKIP_CODE;
                r_prev      <= SKIP_CODE;
                r_cnt       <= '0;
                for (int k = 0; k < NDIG; k++) begin
                    r_dig[k] <= SKIP_CODE;
                end
            end else begin
                r_have_lead <= n_have_lead;
                r_merging   <= n_merging;
                r_lead      <= n_lead;
                r_lead_code <= n_lead_code;
                r_prev      <= n_prev;
                r_cnt       <= n_cnt;
                r_dig       <= n_dig;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (proc && r_in_last) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
        if (proc && r_in_last) begin
            r_out_data <= {out_dig[2], out_dig[1], out_dig[0],
                           n_have_lead ? n_lead : NO_LEAD_CHAR};
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && r_in_last |=> o_m_tvalid)
        else $error("word end did not produce a result");

    a_state_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && r_in_last |=> !r_have_lead && r_cnt == '0 && !r_merging)
        else $error("word state not cleared after word end");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(NDIG))
        else $error("digit count past slot count");

    a_padding_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[9:7] == SKIP_CODE |-> o_m_tdata[15:10] == '0)
        else $error("digit after padding");

    a_no_lead_no_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_have_lead |-> r_cnt == '0)
        else $error("digits without a first letter");

endmodule
`default_nettype wire

// ----- tb/soundex_checker.sv -----
`timescale 1ns / 100ps

// Watches both stream channels of soundex_encoder, predicts the code word
// for every word that closes on the input side, and compares each result
// word against the oldest prediction.
module soundex_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // ch
    input  wire logic        i_s_tlast,   // last
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [15:0] i_m_tdata,   // lead_char, digit_one, digit_two, digit_three
    output int               o_fail_count,
    output int               o_pending
);
    import sdx_pkg::*;

    localparam int NDIG = CODE_LENGTH_DEF - 1;

    typedef struct packed {
        t_code      digit_three;
        t_code      digit_two;
        t_code      digit_one;
        logic [6:0] lead_char;
    } t_sdx_word;

    logic [6:0]  lead_q;
    bit          have_lead_q;
    bit          merging_q;
    t_code       prev_q;
    t_code       digits_q [NDIG];
    int unsigned count_q;
    t_sdx_word   expected_codes [$];
    int          fails;

    function automatic t_code sound_class(input logic [6:0] up);
        case (up)
            "A", "E", "I", "O", "U", "Y":                 return VOWEL_CODE;
            "B", "F", "P", "V":                           return 3'd1;
            "C", "G", "J", "K", "Q", "S", "X", "Z":       return 3'd2;
            "D", "T":                                     return 3'd3;
            "L":                                          return 3'd4;
            "M", "N":                                     return 3'd5;
            "R":                                          return 3'd6;
            default:                                      return SKIP_CODE;
        endcase
    endfunction

    task automatic clear_word();
        lead_q = '0;
        have_lead_q = 0;
        merging_q = 0;
        prev_q = SKIP_CODE;
        count_q = 0;
        for (int k = 0; k < NDIG; k++) digits_q[k] = SKIP_CODE;
    endtask

    task automatic take_byte(input logic [7:0] b, input logic is_last);
        logic [7:0] up;
        t_code      code;
        t_code      outd [3];
        t_sdx_word  w;
        up = b;
        if (b >= ASCII_LOWER_A && b <= ASCII_LOWER_Z) up = b - CASE_OFFSET;
        if (up >= ASCII_UPPER_A && up <= ASCII_UPPER_Z) begin
            code = sound_class(up[6:0]);
            if (!have_lead_q) begin
                lead_q = up[6:0];
                have_lead_q = 1;
                merging_q = (code != SKIP_CODE) && (code != VOWEL_CODE);
                prev_q = SKIP_CODE;
            end else if (code != SKIP_CODE) begin
                // letters sharing the lead's digit in the run right after it fold into the lead
                if (!(merging_q && code == sound_class(lead_q))) begin
                    merging_q = 0;
                    if (code != prev_q) begin
                        prev_q = code;
                        if (code != VOWEL_CODE && count_q < NDIG) begin
                            digits_q[count_q] = code;
                            count_q++;
                        end
                    end
                end
            end
        end
        if (is_last) begin
            for (int k = 0; k < 3; k++)
                outd[k] = (k < NDIG && k < count_q) ? digits_q[k] : SKIP_CODE;
            w.lead_char   = have_lead_q ? lead_q : NO_LEAD_CHAR;
            w.digit_one   = outd[0];
            w.digit_two   = outd[1];
            w.digit_three = outd[2];
            expected_codes.insert(expected_codes.size(), w);
            clear_word();
        end
    endtask

    task automatic check_word(input t_sdx_word got);
        t_sdx_word want;
        if (expected_codes.size() == 0) begin
            $error("result word 0x%04h with no word pending", got);
            fails++;
        end else begin
            want = expected_codes.pop_front();
            if (got.lead_char !== want.lead_char) begin
                $error("lead_char: expected %0d actual %0d", want.lead_char, got.lead_char);
                fails++;
            end
            if (got.digit_one !== want.digit_one) begin
                $error("digit_one: expected %0d actual %0d", want.digit_one, got.digit_one);
                fails++;
            end
            if (got.digit_two !== want.digit_two) begin
                $error("digit_two: expected %0d actual %0d", want.digit_two, got.digit_two);
                fails++;
            end
            if (got.digit_three !== want.digit_three) begin
                $error("digit_three: expected %0d actual %0d",
                       want.digit_three, got.digit_three);
                fails++;
            end
        end
    endtask

    initial begin
        fails = 0;
        clear_word();
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_word();
            expected_codes.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) check_word(i_m_tdata);
            if (i_s_tvalid && i_s_tready) take_byte(i_s_tdata, i_s_tlast);
        end
        o_pending <= expected_codes.size();
        o_fail_count <= fails;
    end

endmodule

// ----- tb/tb_soundex_encoder.sv -----
`timescale 1ns / 100ps

module tb_soundex_encoder;
    import sdx_pkg::*;

    localparam int TOTAL_BYTES = 1850;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 10;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;   // ch
    logic        i_s_tlast;   // last
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [15:0] o_m_tdata;   // lead_char, digit_one, digit_two, digit_three

    int fail_count;
    int pending_words;
    int bytes_sent;
    int tx_idle_pct;
    int rx_idle_pct;
    int hold_ask;
    int hold_seen;
    int hold_left;
    int stall_cycles;

    always #6 i_clk = ~i_clk;

    soundex_encoder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    soundex_checker u_sdx_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tlast    (i_s_tlast),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending_words)
    );

    // Receiver: random back-pressure plus an occasional long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            hold_left <= 0;
            hold_seen <= 0;
        end else if (hold_ask != hold_seen) begin
            hold_seen <= hold_ask;
            hold_left <= HOLD_CYCLES;
            i_m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("tb_soundex_encoder: FAIL");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic is_last);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= b;
        i_s_tlast <= is_last;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_text(input string s, input bit closes);
        for (int k = 0; k < s.len(); k++)
            send_byte(s[k], closes && (k == s.len() - 1));
    endtask

    task automatic send_random_word();
        string      favored;
        int         len;
        int         pick;
        bit         noise_only;
        logic [7:0] b;
        // letters that often repeat a digit or get skipped
        favored = "BFPVHWAECKGDT";
        noise_only = ($urandom_range(0, 24) == 0);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 18) : $urandom_range(1, 8);
        for (int k = 0; k < len; k++) begin
            pick = $urandom_range(0, 99);
            if (noise_only || pick < 15) begin
                b = 8'($urandom_range(0, 255));
            end else begin
                if (pick < 50) b = favored[$urandom_range(0, favored.len() - 1)];
                else b = ASCII_UPPER_A + 8'($urandom_range(0, 25));
                if ($urandom_range(0, 1)) b = b + CASE_OFFSET;
            end
            send_byte(b, k == len - 1);
        end
    endtask

    task automatic wait_all_words();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_words != 0) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata <= '0;
        i_s_tlast <= 1'b0;
        bytes_sent = 0;
        hold_ask = 0;
        tx_idle_pct = 15;
        rx_idle_pct <= 80;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // word with no letters at all
        send_byte(8'h00, 1'b1);
        // H lead, later H and W skipped, closing byte is not a letter
        send_text("Hwh", 0);
        send_byte(8'hFF, 1'b1);
        // mixed case, same-digit letters folded into the lead
        send_text("pfBt", 1);
        // vowel lead, repeated digit, more digits than slots
        send_text("OnnbtlgR", 1);
        // vowel splits two equal digits
        send_text("TaT", 1);
        // W inside a run of the lead's digit
        send_text("bWb", 1);
        wait_all_words();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin tx_idle_pct = 15; rx_idle_pct <= 80; end
                1: begin tx_idle_pct = 80; rx_idle_pct <= 15; end
                default: begin tx_idle_pct = 0; rx_idle_pct <= 0; end
            endcase
            // sink stops for a while; the input side keeps pushing
            hold_ask <= hold_ask + 1;
            while (bytes_sent < TOTAL_BYTES * (phase + 1) / 3) send_random_word();
            wait_all_words();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_soundex_encoder: PASS");
        end else begin
            $display("tb_soundex_encoder: FAIL");
        end
        $finish;
    end

endmodule
